### sv/idll_pkg.sv
package idll_pkg;

    // Pool geometry
    localparam int POOL_DEPTH  = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int LINK_W      = $clog2(POOL_DEPTH + 1);

    typedef logic [IDX_W-1:0]              t_idx;
    typedef logic [LINK_W-1:0]             t_link;
    typedef logic signed [VALUE_WIDTH-1:0] t_val;

    // The null link is one past the last pool entry
    localparam t_link NULL_LINK = t_link'(POOL_DEPTH);

    // Operation codes
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_DELETE = 2'd1;
    localparam logic [1:0] FN_DUMP   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] item_value;
        logic               last;
    } t_out;

    // Pool access: one read address, one write port per array
    typedef struct packed {
        t_idx  rd_addr;
        logic  val_we;
        t_idx  val_waddr;
        t_val  val_wdata;
        logic  next_we;
        t_idx  next_waddr;
        t_link next_wdata;
        logic  prev_we;
        t_idx  prev_waddr;
        t_link prev_wdata;
    } t_mem_req;

    typedef struct packed {
        t_val  value;
        t_link next;
        t_link prev;
    } t_mem_rsp;

    function automatic logic link_null(t_link l);
        return l >= NULL_LINK;
    endfunction

endpackage

### sv/indexed_doubly_linked_list_top.sv
// Insert: S_INS fills the entry, S_INS2 links it behind an old tail, S_RESP gives the result
// beat to the output register; a full pool goes straight to S_RESP. Delete: S_CMP compares
// up to 64 entries, then on a hit S_UNL1 and S_UNL2 unlink and free the match before S_RESP;
// a miss or an empty list ends in S_RESP. Dump: one beat per cycle per entry unless stalled.
// One operation is in progress at a time; the input stalls until its last beat is handed off.
// Synchronous active-low reset empties the list and chains all entries into the free list
// at once; the block is ready for work as soon as reset is released.
module indexed_doubly_linked_list_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  idll_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output idll_pkg::t_out o_out_data,
    input  logic           i_out_stall
);

    idll_pkg::t_mem_req mem_req;
    idll_pkg::t_mem_rsp mem_rsp;
    logic               res_valid;
    logic               res_ready;
    idll_pkg::t_out     res_data;

    logic               r_out_vld;
    idll_pkg::t_out     r_out;

    idll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_req       (mem_req),
        .i_rsp       (mem_rsp),
        .o_res_valid (res_valid),
        .o_res_data  (res_data),
        .i_res_ready (res_ready)
    );

    idll_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    // Output register: take a beat when empty or being drained
    assign res_ready = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= res_valid || (r_out_vld && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res_data;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

### sv/idll_store.sv
module idll_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  idll_pkg::t_mem_req i_req,
    output idll_pkg::t_mem_rsp o_rsp
);

    idll_pkg::t_val  r_val_mem  [idll_pkg::POOL_DEPTH];
    idll_pkg::t_link r_next_mem [idll_pkg::POOL_DEPTH];
    idll_pkg::t_link r_prev_mem [idll_pkg::POOL_DEPTH];
    logic [idll_pkg::POOL_DEPTH-1:0] r_next_set;

    idll_pkg::t_val  r_rd_val;
    idll_pkg::t_link r_rd_next;
    idll_pkg::t_link r_rd_prev;
    logic            r_rd_set;
    idll_pkg::t_idx  r_rd_addr;

    // Write ports
    always_ff @(posedge i_clk) begin
        if (i_req.val_we) begin
            r_val_mem[i_req.val_waddr] <= i_req.val_wdata;
        end
        if (i_req.next_we) begin
            r_next_mem[i_req.next_waddr] <= i_req.next_wdata;
        end
        if (i_req.prev_we) begin
            r_prev_mem[i_req.prev_waddr] <= i_req.prev_wdata;
        end
    end

    // Mark next links written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_set <= '0;
        end else if (i_req.next_we) begin
            r_next_set[i_req.next_waddr] <= 1'b1;
        end
    end

    // Registered read of all three arrays at one address
    always_ff @(posedge i_clk) begin
        r_rd_val  <= r_val_mem[i_req.rd_addr];
        r_rd_next <= r_next_mem[i_req.rd_addr];
        r_rd_prev <= r_prev_mem[i_req.rd_addr];
        r_rd_set  <= r_next_set[i_req.rd_addr];
        r_rd_addr <= i_req.rd_addr;
    end

    // An unwritten next link chains to the following entry
    always_comb begin
        o_rsp.value = r_rd_val;
        o_rsp.prev  = r_rd_prev;
        o_rsp.next  = r_rd_set ? r_rd_next
                               : idll_pkg::t_link'(r_rd_addr) + idll_pkg::t_link'(1);
    end

endmodule

### sv/idll_ctrl.sv
module idll_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  idll_pkg::t_in      i_in_data,
    output logic               o_in_stall,
    output idll_pkg::t_mem_req o_req,
    input  idll_pkg::t_mem_rsp i_rsp,
    output logic               o_res_valid,
    output idll_pkg::t_out     o_res_data,
    input  logic               i_res_ready
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_INS  = 8'b0000_0010,
        S_INS2 = 8'b0000_0100,
        S_CMP  = 8'b0000_1000,
        S_UNL1 = 8'b0001_0000,
        S_UNL2 = 8'b0010_0000,
        S_RESP = 8'b0100_0000,
        S_DMP  = 8'b1000_0000
    } t_state;

    localparam idll_pkg::t_idx K_MAX = idll_pkg::t_idx'(idll_pkg::POOL_DEPTH - 1);

    t_state          r_state, n_state;
    idll_pkg::t_link r_head, n_head;
    idll_pkg::t_link r_tail, n_tail;
    idll_pkg::t_link r_free, n_free;
    idll_pkg::t_link r_cur, n_cur;
    idll_pkg::t_link r_p, n_p;
    idll_pkg::t_link r_nx, n_nx;
    idll_pkg::t_val  r_val, n_val;
    idll_pkg::t_idx  r_k, n_k;
    logic [1:0]      r_status, n_status;
    logic            dump_last;

    assign o_in_stall = (r_state != S_IDLE);
    assign dump_last  = idll_pkg::link_null(i_rsp.next) || (r_k == K_MAX);

    // Sequencer: one pool access per cycle, compare against the held value
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_free   = r_free;
        n_cur    = r_cur;
        n_p      = r_p;
        n_nx     = r_nx;
        n_val    = r_val;
        n_k      = r_k;
        n_status = r_status;

        o_req         = '0;
        o_req.rd_addr = r_cur[idll_pkg::IDX_W-1:0];

        o_res_valid = 1'b0;
        o_res_data  = '{status: r_status, item_value: '0, last: 1'b1};

        unique case (r_state)
            S_IDLE: begin
                o_req.rd_addr = (i_in_data.func == idll_pkg::FN_INSERT)
                              ? r_free[idll_pkg::IDX_W-1:0]
                              : r_head[idll_pkg::IDX_W-1:0];
                if (i_in_valid) begin
                    n_val = idll_pkg::t_val'($signed(i_in_data.value));
                    n_k   = '0;
                    unique case (i_in_data.func)
                        idll_pkg::FN_INSERT: begin
                            if (idll_pkg::link_null(r_free)) begin
                                n_status = idll_pkg::ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_cur   = r_free;
                                n_state = S_INS;
                            end
                        end
                        idll_pkg::FN_DELETE: begin
                            if (idll_pkg::link_null(r_head)) begin
                                n_status = idll_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_cur   = r_head;
                                n_state = S_CMP;
                            end
                        end
                        idll_pkg::FN_DUMP: begin
                            if (idll_pkg::link_null(r_head)) begin
                                n_status = idll_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_cur   = r_head;
                                n_state = S_DMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Fill the new entry and pop it off the free list
            S_INS: begin
                o_req.val_we     = 1'b1;
                o_req.val_waddr  = r_cur[idll_pkg::IDX_W-1:0];
                o_req.val_wdata  = r_val;
                o_req.next_we    = 1'b1;
                o_req.next_waddr = r_cur[idll_pkg::IDX_W-1:0];
                o_req.next_wdata = idll_pkg::NULL_LINK;
                o_req.prev_we    = 1'b1;
                o_req.prev_waddr = r_cur[idll_pkg::IDX_W-1:0];
                n_free           = i_rsp.next;
                n_status         = idll_pkg::ST_OK;
                if (idll_pkg::link_null(r_head) || idll_pkg::link_null(r_tail)) begin
                    o_req.prev_wdata = idll_pkg::NULL_LINK;
                    n_head           = r_cur;
                    n_tail           = r_cur;
                    n_state          = S_RESP;
                end else begin
                    o_req.prev_wdata = r_tail;
                    n_p              = r_tail;
                    n_tail           = r_cur;
                    n_state          = S_INS2;
                end
            end

            // Chain the old tail to the new entry
            S_INS2: begin
                o_req.next_we    = 1'b1;
                o_req.next_waddr = r_p[idll_pkg::IDX_W-1:0];
                o_req.next_wdata = r_cur;
                n_state          = S_RESP;
            end

            // Walk: compare one entry per cycle, read the next one meanwhile
            S_CMP: begin
                if (i_rsp.value == r_val) begin
                    n_p     = i_rsp.prev;
                    n_nx    = i_rsp.next;
                    n_state = S_UNL1;
                end else if (dump_last) begin
                    n_status = idll_pkg::ST_NOTFOUND;
                    n_state  = S_RESP;
                end else begin
                    o_req.rd_addr = i_rsp.next[idll_pkg::IDX_W-1:0];
                    n_cur         = i_rsp.next;
                    n_k           = r_k + idll_pkg::t_idx'(1);
                end
            end

            // Bridge the neighbors around the matched entry
            S_UNL1: begin
                if (!idll_pkg::link_null(r_p)) begin
                    o_req.next_we    = 1'b1;
                    o_req.next_waddr = r_p[idll_pkg::IDX_W-1:0];
                    o_req.next_wdata = r_nx;
                end else begin
                    n_head = r_nx;
                end
                if (!idll_pkg::link_null(r_nx)) begin
                    o_req.prev_we    = 1'b1;
                    o_req.prev_waddr = r_nx[idll_pkg::IDX_W-1:0];
                    o_req.prev_wdata = r_p;
                end else begin
                    n_tail = r_p;
                end
                n_state = S_UNL2;
            end

            // Push the freed entry onto the free list
            S_UNL2: begin
                o_req.next_we    = 1'b1;
                o_req.next_waddr = r_cur[idll_pkg::IDX_W-1:0];
                o_req.next_wdata = r_free;
                n_free           = r_cur;
                n_status         = idll_pkg::ST_OK;
                n_state          = S_RESP;
            end

            // Single status beat
            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            // One beat per entry; hold the read address while stalled
            S_DMP: begin
                o_res_valid = 1'b1;
                o_res_data  = '{status:     idll_pkg::ST_OK,
                                item_value: 32'($signed(i_rsp.value)),
                                last:       dump_last};
                if (i_res_ready) begin
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_req.rd_addr = i_rsp.next[idll_pkg::IDX_W-1:0];
                        n_cur         = i_rsp.next;
                        n_k           = r_k + idll_pkg::t_idx'(1);
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= idll_pkg::NULL_LINK;
            r_tail  <= idll_pkg::NULL_LINK;
            r_free  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_p      <= n_p;
        r_nx     <= n_nx;
        r_val    <= n_val;
        r_k      <= n_k;
        r_status <= n_status;
    end

    a_ends_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head >= idll_pkg::NULL_LINK) == (r_tail >= idll_pkg::NULL_LINK))
        else $error("list head and tail disagree on empty");

    a_full_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free >= idll_pkg::NULL_LINK) |-> (r_head < idll_pkg::NULL_LINK))
        else $error("free list exhausted with an empty list");

    a_walk_linked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP || r_state == S_DMP) |-> (r_cur < idll_pkg::NULL_LINK))
        else $error("walk reached a null entry");

    a_beat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_res_data)))
        else $error("result beat changed while held");

endmodule

### dv/idll_checker.sv
module idll_checker
    import idll_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_cmds,
    output int   o_beats,
    output int   o_full_hits,
    output int   o_longest_dump
);

    localparam int NIL = POOL_DEPTH;
    localparam int PRINT_CAP = 50;

    // Shadow copy of the pool and its list pointers
    logic [31:0] pool_val  [POOL_DEPTH];
    int          pool_next [POOL_DEPTH];
    int          pool_prev [POOL_DEPTH];
    int          list_first;
    int          list_final;
    int          free_first;

    // Output beats still owed by the block, oldest first
    t_out due_beats[$];

    function automatic t_out make_beat(logic [1:0] st, logic [31:0] v, logic fin);
        t_out b;
        b.status     = st;
        b.item_value = v;
        b.last       = fin;
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        o_fail_count++;
        if (o_fail_count <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    // Empty list, every entry chained into the free list
    task automatic clear_pool();
        for (int i = 0; i < POOL_DEPTH; i++) begin
            pool_next[i] = i + 1;
            pool_prev[i] = NIL;
            pool_val[i]  = '0;
        end
        list_first = NIL;
        list_final = NIL;
        free_first = 0;
    endtask

    // Take the free-list head and link it behind the tail
    task automatic append_value(logic [31:0] v, output logic [1:0] st);
        int n;
        n = free_first;
        if (n >= NIL) begin
            st = ST_FULL;
            return;
        end
        free_first   = pool_next[n];
        pool_val[n]  = v;
        pool_next[n] = NIL;
        if (list_first >= NIL || list_final >= NIL) begin
            pool_prev[n] = NIL;
            list_first   = n;
            list_final   = n;
        end else begin
            pool_prev[n]          = list_final;
            pool_next[list_final] = n;
            list_final            = n;
        end
        st = ST_OK;
    endtask

    // Walk from the head, unlink the first match and push it onto the free list
    task automatic unlink_first(logic [31:0] v, output logic [1:0] st);
        int cur;
        int p;
        int nx;
        cur = list_first;
        if (cur >= NIL) begin
            st = ST_EMPTY;
            return;
        end
        for (int steps = 0; steps < POOL_DEPTH && cur < NIL; steps++) begin
            if (pool_val[cur] == v) begin
                p  = pool_prev[cur];
                nx = pool_next[cur];
                if (p < NIL)
                    pool_next[p] = nx;
                else
                    list_first = nx;
                if (nx < NIL)
                    pool_prev[nx] = p;
                else
                    list_final = p;
                pool_prev[cur] = NIL;
                pool_next[cur] = free_first;
                free_first     = cur;
                st = ST_OK;
                return;
            end
            cur = pool_next[cur];
        end
        st = ST_NOTFOUND;
    endtask

    // Apply one command to the shadow list and queue the beats it owes
    task automatic predict_command(t_in cmd);
        logic [1:0] st;
        int         cur;
        int         nx;
        int         k;
        logic       fin;
        case (cmd.func)
            FN_INSERT: begin
                append_value(cmd.value, st);
                if (st == ST_FULL)
                    o_full_hits++;
                due_beats.push_back(make_beat(st, '0, 1'b1));
            end
            FN_DELETE: begin
                unlink_first(cmd.value, st);
                due_beats.push_back(make_beat(st, '0, 1'b1));
            end
            FN_DUMP: begin
                cur = list_first;
                if (cur >= NIL) begin
                    due_beats.push_back(make_beat(ST_EMPTY, '0, 1'b1));
                end else begin
                    k = 0;
                    while (k < POOL_DEPTH && cur < NIL) begin
                        nx  = pool_next[cur];
                        fin = (nx >= NIL) || (k + 1 >= POOL_DEPTH);
                        due_beats.push_back(make_beat(ST_OK, pool_val[cur], fin));
                        k++;
                        cur = nx;
                    end
                    if (k > o_longest_dump)
                        o_longest_dump = k;
                end
            end
            default: begin
                // spare code: no beats, no change
            end
        endcase
    endtask

    // Compare one output beat against the oldest owed beat
    task automatic check_beat(t_out got);
        t_out want;
        if (due_beats.size() == 0) begin
            report_mismatch("unrequested beat", got.item_value, '0);
            return;
        end
        want = due_beats.pop_front();
        if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.item_value != want.item_value)
            report_mismatch("item_value", got.item_value, want.item_value);
        if (got.last != want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    // Score the output side before taking in the new command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_pool();
            due_beats.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_beats++;
                check_beat(i_out_data);
            end
            if (i_in_valid && !i_in_stall) begin
                o_cmds++;
                predict_command(i_in_data);
            end
        end
        o_pending = due_beats.size();
    end

endmodule

### dv/tb_indexed_doubly_linked_list_top.sv
module tb_indexed_doubly_linked_list_top;
    import idll_pkg::*;

    localparam logic [1:0] FN_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 150;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;
    logic i_out_stall = 1'b0;

    int fail_count;
    int pending;
    int cmd_count;
    int beat_count;
    int full_hits;
    int longest_dump;
    int cycle_count = 0;

    // Values that are reused often so deletes find matches and duplicates occur
    logic [31:0] hot_values [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0002,
                                    32'h0000_0005, 32'h1234_5678};

    // Values currently held in the list, as a multiset, to aim deletes
    logic [31:0] live_values[$];

    indexed_doubly_linked_list_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    idll_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_data      (i_in_data),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_data     (o_out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_cmds         (cmd_count),
        .o_beats        (beat_count),
        .o_full_hits    (full_hits),
        .o_longest_dump (longest_dump)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still owed", cycle_count, pending);
            $display("indexed_doubly_linked_list_top verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 30);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(15, 30);
    endfunction

    function automatic logic [31:0] pick_value(int pct_hot);
        if ($urandom_range(0, 99) < pct_hot)
            return hot_values[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // Receiver backpressure: short and long stalls with quiet stretches between
    initial begin
        int hold;
        int r;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    i_out_stall <= 1'b0;
                    hold = $urandom_range(50, 150) - 1;
                end else if (r < 60) begin
                    i_out_stall <= 1'b0;
                    hold = $urandom_range(0, 6);
                end else begin
                    i_out_stall <= 1'b1;
                    hold = pick_stall() - 1;
                end
            end
        end
    end

    // Present one command, hold it until accepted, then idle for a random gap
    task automatic send_cmd(logic [1:0] func, logic [31:0] value);
        t_in beat;
        int  gap;
        beat.func  = func;
        beat.value = value;
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic put_value(logic [31:0] v);
        if (live_values.size() < POOL_DEPTH)
            live_values.push_back(v);
        send_cmd(FN_INSERT, v);
    endtask

    // Drop one copy of the value from the live set, if held, then delete it
    task automatic take_value(logic [31:0] v);
        int idx;
        idx = -1;
        for (int i = 0; i < live_values.size(); i++) begin
            if (idx < 0 && live_values[i] == v)
                idx = i;
        end
        if (idx >= 0)
            live_values.delete(idx);
        send_cmd(FN_DELETE, v);
    endtask

    // Weighted mix of commands; deletes mostly hit a held value
    task automatic random_phase(int count, int pct_ins, int pct_del);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < pct_ins) begin
                put_value(pick_value(70));
            end else if (r < pct_ins + pct_del) begin
                if (live_values.size() > 0 && $urandom_range(0, 99) < 85)
                    take_value(live_values[$urandom_range(0, live_values.size() - 1)]);
                else
                    take_value($urandom());
            end else if (r < 98) begin
                send_cmd(FN_DUMP, $urandom());
            end else begin
                send_cmd(FN_SPARE, $urandom());
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list, spare code, then value extremes with a duplicate
        send_cmd(FN_DUMP, 32'h0000_0000);
        take_value(32'h0000_0005);
        send_cmd(FN_SPARE, 32'hFFFF_FFFF);
        put_value(32'h8000_0000);
        put_value(32'h7FFF_FFFF);
        put_value(32'h0000_0000);
        put_value(32'hFFFF_FFFF);
        put_value(32'h0000_0005);
        put_value(32'h0000_0005);
        send_cmd(FN_DUMP, 32'hFFFF_FFFF);
        // Miss, middle, head, first of duplicates, tail, then down to empty
        take_value(32'h1234_5678);
        take_value(32'h7FFF_FFFF);
        take_value(32'h8000_0000);
        take_value(32'h0000_0005);
        send_cmd(FN_DUMP, 32'h0000_0000);
        take_value(32'h0000_0005);
        take_value(32'h0000_0000);
        take_value(32'hFFFF_FFFF);
        send_cmd(FN_DUMP, 32'h0000_0000);
        take_value(32'hFFFF_FFFF);
        put_value(32'h5555_5555);
        put_value(32'hAAAA_AAAA);
        send_cmd(FN_DUMP, 32'h5555_5555);

        // Fill past full, mix, drain, mix again
        random_phase(80, 90, 6);
        random_phase(25, 45, 38);
        random_phase(70, 8, 88);
        random_phase(5, 50, 40);

        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands and %0d output beats in %0d cycles", cmd_count,
                 beat_count, cycle_count);
        $display("Pool-full drops: %0d, longest dump: %0d entries", full_hits, longest_dump);
        if (pending != 0)
            $display("%0d expected beats never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("indexed_doubly_linked_list_top verification clean");
        end else begin
            $display("indexed_doubly_linked_list_top verification failed");
        end
        $finish;
    end

endmodule
